@@ rtl/core/countdown_timer_with_digit_setting_macros.svh @@
// assertion macros shared by the countdown timer rtl
// no dependencies; pulled in by the modules that carry assertions
`ifndef COUNTDOWN_TIMER_WITH_DIGIT_SETTING_MACROS_SVH
`define COUNTDOWN_TIMER_WITH_DIGIT_SETTING_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TMR_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("timer check failed");

// next-cycle implication, disabled while reset is asserted
`define TMR_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("timer check failed");

`endif

@@ rtl/core/tmr_pkg.sv @@
// shared types and constants of the countdown timer
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package tmr_pkg;

  localparam int unsigned MsW      = 16;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned SecW     = 6;
  localparam int unsigned CfgAddrW = 8;

  localparam logic [MsW-1:0]    LockoutRst = 16'd200;
  localparam logic [MsW-1:0]    TickRst    = 16'd1000;
  localparam logic [DigitW-1:0] DigitMax   = 4'd9;
  localparam logic [SecW-1:0]   SecMax     = 6'd59;
  localparam logic [SecW:0]     SecLimit   = 7'd60;
  localparam logic [SecW:0]     SecStep    = 7'd10;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_PRESS_LOCKOUT = 8'd0,
    CFG_TICK_PERIOD   = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic           start_button;
    logic           stop_button;
    logic           ten_minute_button;
    logic           minute_button;
    logic           ten_second_button;
    logic [MsW-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic              running;
    logic [DigitW-1:0] ten_minutes_digit;
    logic [DigitW-1:0] minutes_digit;
    logic [SecW-1:0]   seconds_value;
  } out_t;

  typedef struct packed {
    logic [CfgAddrW-1:0] addr;
    logic [MsW-1:0]      data;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/tmr_in_if.sv @@
// valid/ready channel carrying one button sample per transaction
// depends on tmr_pkg
`default_nettype none

interface tmr_in_if;
  import tmr_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tmr_out_if.sv @@
// valid/ready channel carrying one timer result per transaction
// depends on tmr_pkg
`default_nettype none

interface tmr_out_if;
  import tmr_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tmr_cfg_if.sv @@
// valid/ready register write channel, index plus data
// depends on tmr_pkg
`default_nettype none

interface tmr_cfg_if;
  import tmr_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/countdown_timer_with_digit_setting.sv @@
// top level of the mm:ss countdown timer with button digit setting
// depends on tmr_pkg, the tmr_*_if channel interfaces and the macros header
`default_nettype none
`include "countdown_timer_with_digit_setting_macros.svh"

// Countdown timer, MM:SS. Every input transaction is one sample of five
// buttons plus a 16-bit millisecond timestamp, and every input transaction
// produces exactly one output transaction with the run flag and the three
// time fields after that sample. While stopped, rising edges on the set
// buttons step the ten-minutes digit, the minutes digit and the seconds
// (by ten, wrapping at 60), each press only if press_lockout_ms has gone
// by since the last accepted event. While running, the time counts down one
// second per tick_period_ms. Timing: a sample is held in the input
// register, then the full update runs through one pass of logic into the
// state and result registers; one sample is taken every cycle as long as
// the result side keeps up, and the result register is the only thing that
// can hold off the input. Registers are written through the config channel
// (index 0 lockout, index 1 tick period, other indexes ignored) and should
// only be written while idle.
module countdown_timer_with_digit_setting (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tmr_in_if.sink    in_i,
  tmr_out_if.source out_o,
  tmr_cfg_if.sink   cfg_i
);
  import tmr_pkg::*;

  // ---------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------
  logic [MsW-1:0] lockout_q, tick_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LockoutRst;
      tick_q    <= TickRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.addr)
        CFG_PRESS_LOCKOUT: lockout_q <= cfg_i.data.data;
        CFG_TICK_PERIOD:   tick_q    <= cfg_i.data.data;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: input register feeding the result register
  // ---------------------------------------------------------------------
  logic in_valid_q, out_valid_q, advance;
  in_t  in_q;
  out_t out_q, out_d;

  // the update fires when a sample is held and the result slot is free
  // or being drained in this same cycle
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------
  // timer state
  // ---------------------------------------------------------------------
  logic              run_q, run_d;
  logic [DigitW-1:0] tens_q, tens_d, units_q, units_d;
  logic [SecW-1:0]   secs_q, secs_d;
  logic [MsW-1:0]    last_q, last_d;
  logic              lvl10m_q, lvl1m_q, lvl10s_q;
  logic              lvl10m_d, lvl1m_d, lvl10s_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      tens_q   <= '0;
      units_q  <= '0;
      secs_q   <= '0;
      last_q   <= '0;
      lvl10m_q <= 1'b0;
      lvl1m_q  <= 1'b0;
      lvl10s_q <= 1'b0;
    end else if (advance) begin
      run_q    <= run_d;
      tens_q   <= tens_d;
      units_q  <= units_d;
      secs_q   <= secs_d;
      last_q   <= last_d;
      lvl10m_q <= lvl10m_d;
      lvl1m_q  <= lvl1m_d;
      lvl10s_q <= lvl10s_d;
    end
  end

  // ---------------------------------------------------------------------
  // single-pass update
  // ---------------------------------------------------------------------
  logic [MsW-1:0]    elapsed;
  logic              lock_ok, lock_zero, tick_due;
  logic              rise10m, rise1m, rise10s;
  logic              acc10m, acc1m, acc10s;
  logic              ok1m, ok10s;
  logic              run_a;
  logic [DigitW-1:0] tens_a, units_a;
  logic [SecW-1:0]   secs_a;
  logic [SecW:0]     secs_sum;

  // all timestamp differences wrap modulo 2^16
  assign elapsed   = in_q.now_ms - last_q;
  assign lock_ok   = elapsed >= lockout_q;
  assign lock_zero = lockout_q == '0;
  assign tick_due  = elapsed >= tick_q;

  // a press accepted earlier in the same sample moves the event time to now,
  // so later presses in that sample only pass with a zero lockout
  assign rise10m = in_q.ten_minute_button && !lvl10m_q;
  assign rise1m  = in_q.minute_button && !lvl1m_q;
  assign rise10s = in_q.ten_second_button && !lvl10s_q;
  assign acc10m  = !run_q && rise10m && lock_ok;
  assign ok1m    = acc10m ? lock_zero : lock_ok;
  assign acc1m   = !run_q && rise1m && ok1m;
  assign ok10s   = (acc10m || acc1m) ? lock_zero : lock_ok;
  assign acc10s  = !run_q && rise10s && ok10s;

  always_comb begin
    // start wins over stop
    run_a   = run_q;
    tens_a  = tens_q;
    units_a = units_q;
    secs_a  = secs_q;
    if (in_q.start_button) begin
      run_a = (tens_q != '0) || (units_q != '0) || (secs_q != '0);
    end else if (in_q.stop_button) begin
      run_a   = 1'b0;
      tens_a  = '0;
      units_a = '0;
      secs_a  = '0;
    end

    run_d    = run_a;
    tens_d   = tens_a;
    units_d  = units_a;
    secs_d   = secs_a;
    last_d   = last_q;
    lvl10m_d = lvl10m_q;
    lvl1m_d  = lvl1m_q;
    lvl10s_d = lvl10s_q;
    secs_sum = {1'b0, secs_a} + SecStep;

    if (!run_q) begin
      // stopped: track button levels and apply accepted presses
      lvl10m_d = in_q.ten_minute_button;
      lvl1m_d  = in_q.minute_button;
      lvl10s_d = in_q.ten_second_button;
      if (acc10m) begin
        tens_d = (tens_a >= DigitMax) ? '0 : tens_a + 4'd1;
      end
      if (acc1m) begin
        units_d = (units_a >= DigitMax) ? '0 : units_a + 4'd1;
      end
      if (acc10s) begin
        secs_d = (secs_sum >= SecLimit) ? '0 : secs_sum[SecW-1:0];
      end
      if (acc10m || acc1m || acc10s) begin
        last_d = in_q.now_ms;
      end
    end else begin
      // running: stop at zero, else count one second down per tick
      if ((tens_a == '0) && (units_a == '0) && (secs_a == '0)) begin
        run_d = 1'b0;
      end else if (tick_due) begin
        last_d = in_q.now_ms;
        if (secs_a != '0) begin
          secs_d = secs_a - 6'd1;
        end else begin
          secs_d = SecMax;
          if (units_a != '0) begin
            units_d = units_a - 4'd1;
          end else begin
            units_d = DigitMax;
            tens_d  = tens_a - 4'd1;
          end
        end
      end
    end

    out_d.running           = run_d;
    out_d.ten_minutes_digit = tens_d;
    out_d.minutes_digit     = units_d;
    out_d.seconds_value     = secs_d;
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `TMR_ASSERT_IMP(a_digits_in_range, clk_i, rst_ni, 1'b1,
    (tens_q <= DigitMax) && (units_q <= DigitMax) && (secs_q <= SecMax))
  `TMR_ASSERT_NXT(a_update_fills_result, clk_i, rst_ni, advance, out_valid_q)
  `TMR_ASSERT_NXT(a_state_holds_when_idle, clk_i, rst_ni, !advance,
    $stable(run_q) && $stable(tens_q) && $stable(units_q) && $stable(secs_q)
    && $stable(last_q))
  `TMR_ASSERT_NXT(a_sample_held_when_blocked, clk_i, rst_ni, in_valid_q && !advance,
    in_valid_q && $stable(in_q))

endmodule

`default_nettype wire
